>>> rtl/ush_pkg.sv
`default_nettype none

package ush_pkg;

    localparam int unsigned RETRY_LIMIT = 200;
    localparam int unsigned ATT_W = $clog2(RETRY_LIMIT + 1);

    localparam logic [3:0] PID_NONE  = 4'h0;
    localparam logic [3:0] PID_OUT   = 4'h1;
    localparam logic [3:0] PID_ACK   = 4'h2;
    localparam logic [3:0] PID_DATA0 = 4'h3;
    localparam logic [3:0] PID_IN    = 4'h9;
    localparam logic [3:0] PID_NAK   = 4'hA;
    localparam logic [3:0] PID_DATA1 = 4'hB;
    localparam logic [3:0] PID_SETUP = 4'hD;
    localparam logic [3:0] PID_STALL = 4'hE;

    localparam logic [15:0] NAK_FOREVER = 16'hFFFF;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_ANSWER = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_STALL     = 3'd1;
    localparam logic [2:0] ST_NAK_TMO   = 3'd2;
    localparam logic [2:0] ST_BAD_PID   = 3'd3;
    localparam logic [2:0] ST_RETRY_EXH = 3'd4;
    localparam logic [2:0] ST_NO_ANSWER = 3'd5;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  token_pid;
        logic        expect_data1;
        logic [15:0] nak_budget;
        logic        answered;
        logic [3:0]  resp_pid;
        logic        toggle_ok;
    } item_t;

    typedef struct packed {
        logic       send_token;
        logic       done_res;
        logic [2:0] status;
        logic [3:0] final_pid;
    } result_t;

    typedef struct packed {
        logic             busy;
        logic [ATT_W-1:0] attempts;
    } eng_status_t;

endpackage

`default_nettype wire

>>> rtl/ush_in_stage.sv
`default_nettype none

module ush_in_stage
    import ush_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ush_engine.sv
`default_nettype none

module ush_engine
    import ush_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result,
    output eng_status_t eng_status
);

    logic             busy_reg, busy_next;
    logic [3:0]       kind_reg, kind_next;
    logic             want1_reg, want1_next;
    logic [15:0]      naks_reg, naks_next;
    logic [ATT_W-1:0] att_reg, att_next;
    logic [ATT_W:0]   att_inc;
    logic             fall_through;

    assign att_inc    = {1'b0, att_reg} + 1'b1;
    assign eng_status = '{busy: busy_reg, attempts: att_reg};

    always_comb begin
        busy_next    = busy_reg;
        kind_next    = kind_reg;
        want1_next   = want1_reg;
        naks_next    = naks_reg;
        att_next     = att_reg;
        result       = '0;
        fall_through = 1'b0;

        if (item.cmd == CMD_START) begin
            kind_next         = item.token_pid;
            want1_next        = item.expect_data1;
            naks_next         = item.nak_budget;
            att_next          = '0;
            busy_next         = 1'b1;
            result.send_token = 1'b1;
        end else if (busy_reg) begin
            result.done_res = 1'b1;
            if (!item.answered) begin
                result.status = ST_NO_ANSWER;
            end else if (item.toggle_ok) begin
                result.status = ST_OK;
            end else if (item.resp_pid == PID_STALL) begin
                result.status    = ST_STALL;
                result.final_pid = item.resp_pid;
            end else if (item.resp_pid == PID_NAK) begin
                if (naks_reg == '0) begin
                    result.status    = ST_NAK_TMO;
                    result.final_pid = item.resp_pid;
                end else begin
                    if (naks_reg != NAK_FOREVER) begin
                        naks_next = naks_reg - 1'b1;
                    end
                    result.done_res   = 1'b0;
                    result.send_token = 1'b1;
                end
            end else begin
                unique case (kind_reg) inside
                    PID_SETUP, PID_OUT: begin
                        fall_through = (item.resp_pid != PID_ACK);
                    end
                    PID_IN: begin
                        fall_through = (item.resp_pid != (want1_reg ? PID_DATA1 : PID_DATA0));
                    end
                    default: begin
                        result.status = ST_NO_ANSWER;
                    end
                endcase
                if (fall_through) begin
                    if (item.resp_pid != PID_NONE) begin
                        result.status    = ST_BAD_PID;
                        result.final_pid = item.resp_pid;
                    end else if (att_inc >= (ATT_W + 1)'(RETRY_LIMIT)) begin
                        result.status = ST_RETRY_EXH;
                    end else begin
                        att_next          = att_inc[ATT_W-1:0];
                        result.done_res   = 1'b0;
                        result.send_token = 1'b1;
                    end
                end
            end
            if (result.done_res) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            kind_reg  <= '0;
            want1_reg <= 1'b0;
            naks_reg  <= '0;
            att_reg   <= '0;
        end else if (fire) begin
            busy_reg  <= busy_next;
            kind_reg  <= kind_next;
            want1_reg <= want1_next;
            naks_reg  <= naks_next;
            att_reg   <= att_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ush_out_stage.sv
`default_nettype none

module ush_out_stage
    import ush_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    held_valid,
    input  wire result_t result,
    output logic         advance,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result
);

    logic    valid_reg;
    result_t res_reg;

    // an item moves on when the result slot is free or being emptied
    assign advance    = held_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/usb_transaction_handshake.sv
// channel  | direction | tdata (low bit up)                                  | tuser / tlast
// s_       | in        | token_pid, expect_data1, nak_budget, answered,      | tuser: cmd
//          |           | resp_pid, toggle_ok, zero pad to 32                 |
// m_       | out       | send_token, status, final_pid                       | tlast: done_res
//
// one item per cycle sustained while m_tready stays high; m_tvalid rises once an accepted s_ item has passed
// the input register, the decision logic on the small counters and the result register
// aresetn is synchronous and clears the valid flags and the transaction state
// a stall on m_tready backs up through the input register to s_tready

`default_nettype none

module usb_transaction_handshake
    import ush_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // token_pid[3:0], expect_data1[4], nak_budget[20:5],
                                       // answered[21], resp_pid[25:22], toggle_ok[26]
    input  wire logic        s_tuser,  // cmd[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // send_token[0], status[3:1], final_pid[7:4]
    output logic             m_tlast
);

    item_t       in_item;
    item_t       held_item;
    logic        held_valid;
    logic        advance;
    result_t     result;
    result_t     out_result;
    eng_status_t eng_status;

    assign in_item.cmd          = s_tuser;
    assign in_item.token_pid    = s_tdata[3:0];
    assign in_item.expect_data1 = s_tdata[4];
    assign in_item.nak_budget   = s_tdata[20:5];
    assign in_item.answered     = s_tdata[21];
    assign in_item.resp_pid     = s_tdata[25:22];
    assign in_item.toggle_ok    = s_tdata[26];

    ush_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ush_engine u_eng (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .item       (held_item),
        .result     (result),
        .eng_status (eng_status)
    );

    ush_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .held_valid (held_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {out_result.final_pid, out_result.status, out_result.send_token};
    assign m_tlast = out_result.done_res;

    // empty-response retries never reach the limit while a transaction runs
    a_attempts_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.attempts < ATT_W'(RETRY_LIMIT))
        else $error("retry counter reached the limit");

    // the transaction ends only together with a final result
    a_busy_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(eng_status.busy) |-> m_tvalid && m_tlast)
        else $error("busy dropped without a final result");

    // a final result never asks for the token, a non-final one carries no status
    a_done_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast ? !m_tdata[0] : (m_tdata[7:1] == '0)))
        else $error("result fields inconsistent with done flag");

    // a new start always issues the token
    a_start_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && held_item.cmd == CMD_START |=> m_tvalid && m_tdata[0] && !m_tlast)
        else $error("start did not request the token");

endmodule

`default_nettype wire
